// File: src/pba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page bitmap allocator package
// Field widths, command and status codes and default sizes used by the
// allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

   localparam int PAGES_DEFAULT     = 4096;
   localparam int WORD_BITS_DEFAULT = 32;

   localparam int CMD_W    = 3;
   localparam int PAGE_W   = 12;
   localparam int COUNT_W  = 13;
   localparam int LIMIT_W  = 13;
   localparam int STATUS_W = 2;
   localparam int EVENT_W  = 32;

   localparam logic [LIMIT_W-1:0] LOW_WATER_RESET = LIMIT_W'(4096);

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC     = 3'd0,
      CMD_FREE      = 3'd1,
      CMD_QUERY     = 3'd2,
      CMD_RESERVE   = 3'd3,
      CMD_UNRESERVE = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_NO_RUN   = 2'd1,
      STATUS_REJECTED = 2'd2
   } status_type;

   typedef enum logic {
      CSR_PAGE_LIMIT = 1'b0,
      CSR_ENABLED    = 1'b1
   } csr_index_type;

endpackage

// File: src/pba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page bitmap allocator RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module pba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/page_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page bitmap allocator
// First-fit page allocator keeping one used bit per page in a word memory.
// ----------------------------------------------------------------------------
// Commands arrive on the req_ channel and each one returns exactly one word on
// the rsp_ channel with a status, the allocated start page, the query answer
// and a snapshot of all counters. The csr_ channel writes the page limit and
// the enable bit; it is always ready. The user must write it only while the
// block idles; the block itself does not enforce this. One command is worked
// on at a time: req_stall is high from acceptance until the result has been
// loaded into the output register. Rejected, zero-count and disabled
// commands go straight to the reply state; a query reads its map word first.
// Free, reserve and unreserve read, modify and write one map word per cycle.
// Allocate scans the map one word per cycle from page 0 up to the page limit
// and then marks the run. The single map memory port sets this pace.
// After reset every page reads as used, all counters are clear, the low-water
// mark is 4096 and the block is disabled. A stalled result word holds; the next
// result waits in the reply state until the output register is free.
// ----------------------------------------------------------------------------
module page_bitmap_allocator #(
   parameter int PAGES     = pba_pkg::PAGES_DEFAULT,
   parameter int WORD_BITS = pba_pkg::WORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [pba_pkg::CMD_W-1:0]    req_command,
   input  logic [pba_pkg::PAGE_W-1:0]   req_page_number,
   input  logic [pba_pkg::COUNT_W-1:0]  req_page_count,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pba_pkg::STATUS_W-1:0] rsp_status,
   output logic [pba_pkg::PAGE_W-1:0]   rsp_first_page,
   output logic                         rsp_is_allocated,
   output logic [pba_pkg::LIMIT_W-1:0]  rsp_free_total,
   output logic [pba_pkg::LIMIT_W-1:0]  rsp_free_low_water,
   output logic [pba_pkg::EVENT_W-1:0]  rsp_reserved_total,
   output logic [pba_pkg::EVENT_W-1:0]  rsp_allocated_events,
   output logic [pba_pkg::EVENT_W-1:0]  rsp_freed_events,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [pba_pkg::LIMIT_W-1:0]  csr_data
);

   localparam int WB      = WORD_BITS;
   localparam int LB      = $clog2(WB);
   localparam int WORDS   = (PAGES + WB - 1) / WB;
   localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int LW      = pba_pkg::LIMIT_W;
   localparam int XW      = LW + 1;
   localparam int PCW     = LB + 1;
   localparam int EW      = pba_pkg::EVENT_W;
   localparam int LIM_MAX = (PAGES > 8191) ? 8191 : PAGES;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_WRITE = 5'b00100,
      ST_QUERY = 5'b01000,
      ST_REPLY = 5'b10000
   } state_type;

   function automatic logic [PCW-1:0] popcount(input logic [WB-1:0] v);
      logic [PCW-1:0] n;
      n = '0;
      for (int i = 0; i < WB; i++) begin
         n = n + PCW'(v[i]);
      end
      return n;
   endfunction

   state_type                    state_ff, state_in;
   pba_pkg::cmd_type             cmd_ff, cmd_in;
   logic [XW-1:0]                lo_ff, lo_in, hi_ff, hi_in;
   logic [pba_pkg::COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [AW-1:0]                word_ff, word_in, last_ff, last_in;
   logic [XW-1:0]                run_ff, run_in, run_start_ff, run_start_in;
   logic [LB-1:0]                bit_sel_ff, bit_sel_in;
   logic [pba_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [XW-1:0]                start_ff, start_in;
   logic                         isalloc_ff, isalloc_in;
   logic [LW-1:0]                free_ff, free_in, low_ff, low_in;
   logic [EW-1:0]                resv_ff, resv_in, alloc_ff, alloc_in, freed_ff, freed_in;
   logic [LW-1:0]                page_limit_ff;
   logic                         enabled_ff;
   logic [WORDS-1:0]             row_valid_ff;
   logic                         rowv_ff;

   logic                         rsp_valid_ff;
   logic [pba_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [pba_pkg::PAGE_W-1:0]   rsp_start_ff;
   logic                         rsp_isalloc_ff;
   logic [LW-1:0]                rsp_free_ff, rsp_low_ff;
   logic [EW-1:0]                rsp_resv_ff, rsp_alloc_ff, rsp_freed_ff;

   logic                         rd_en, wr_en;
   logic [AW-1:0]                rd_addr;
   logic [WB-1:0]                ram_q, word_q, wr_data;
   logic [XW-1:0]                lim_x, base, req_end, req_hi, found_page, new_hi;
   logic                         accept, out_free;
   logic [WB-1:0]                used_v, mask_v;
   logic                         has_v [WB];
   logic [LB-1:0]                lastk_v [WB];
   logic [WB-1:0]                ok_v;
   logic [XW-1:0]                len_v;
   logic                         hit;
   logic [LB-1:0]                hit_j;
   logic [PCW-1:0]               changed_n, range_n;
   logic [LW-1:0]                free_alloc;

   pba_ram #(
      .WIDTH (WB),
      .DEPTH (WORDS),
      .AW    (AW)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign lim_x   = (page_limit_ff > LW'(LIM_MAX)) ? XW'(LIM_MAX) : XW'(page_limit_ff);
   assign base    = XW'({word_ff, LB'(0)});
   assign word_q  = rowv_ff ? ram_q : '1;
   assign req_end = XW'(req_page_number) + XW'(req_page_count);
   assign req_hi  = (req_end > lim_x) ? lim_x : req_end;

   always_comb begin
      for (int j = 0; j < WB; j++) begin
         used_v[j] = word_q[j] | ((base + XW'(j)) >= lim_x);
         mask_v[j] = ((base + XW'(j)) >= lo_ff) && ((base + XW'(j)) < hi_ff);
      end
      for (int j = 0; j < WB; j++) begin
         has_v[j]   = 1'b0;
         lastk_v[j] = '0;
         for (int k = 0; k <= j; k++) begin
            if (used_v[k]) begin
               has_v[j]   = 1'b1;
               lastk_v[j] = LB'(k);
            end
         end
      end
      for (int j = 0; j < WB; j++) begin
         len_v    = has_v[j] ? (XW'(j) - XW'(lastk_v[j])) : (run_ff + XW'(j + 1));
         ok_v[j]  = !used_v[j] && (len_v >= XW'(cnt_ff));
      end
      hit   = 1'b0;
      hit_j = '0;
      for (int j = WB - 1; j >= 0; j--) begin
         if (ok_v[j]) begin
            hit   = 1'b1;
            hit_j = LB'(j);
         end
      end
      if (has_v[hit_j]) begin
         found_page = base + XW'(lastk_v[hit_j]) + XW'(1);
      end else if (run_ff == '0) begin
         found_page = base;
      end else begin
         found_page = run_start_ff;
      end
   end

   assign new_hi     = found_page + XW'(cnt_ff);
   assign free_alloc = (free_ff >= LW'(cnt_ff)) ? (free_ff - LW'(cnt_ff)) : '0;
   assign wr_data    = (cmd_ff == pba_pkg::CMD_ALLOC || cmd_ff == pba_pkg::CMD_RESERVE)
                       ? (word_q | mask_v) : (word_q & ~mask_v);
   assign changed_n  = popcount(word_q ^ wr_data);
   assign range_n    = popcount(mask_v);
   assign wr_en      = (state_ff == ST_WRITE);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cnt_in       = cnt_ff;
      word_in      = word_ff;
      last_in      = last_ff;
      run_in       = run_ff;
      run_start_in = run_start_ff;
      bit_sel_in   = bit_sel_ff;
      status_in    = status_ff;
      start_in     = start_ff;
      isalloc_in   = isalloc_ff;
      free_in      = free_ff;
      low_in       = low_ff;
      resv_in      = resv_ff;
      alloc_in     = alloc_ff;
      freed_in     = freed_ff;
      rd_en        = 1'b0;
      rd_addr      = word_ff + AW'(1);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in     = pba_pkg::cmd_type'(req_command);
               cnt_in     = req_page_count;
               status_in  = pba_pkg::STATUS_DONE;
               start_in   = '0;
               isalloc_in = 1'b0;
               state_in   = ST_REPLY;
               bit_sel_in = LB'(req_page_number);
               if (!enabled_ff) begin
                  status_in  = pba_pkg::STATUS_REJECTED;
                  isalloc_in = (req_command == pba_pkg::CMD_QUERY);
               end else if (req_command == pba_pkg::CMD_ALLOC) begin
                  if (req_page_count == '0) begin
                     status_in = pba_pkg::STATUS_DONE;
                  end else if (lim_x == '0) begin
                     status_in = pba_pkg::STATUS_NO_RUN;
                  end else begin
                     rd_en        = 1'b1;
                     rd_addr      = '0;
                     word_in      = '0;
                     last_in      = AW'((lim_x - XW'(1)) >> LB);
                     run_in       = '0;
                     run_start_in = '0;
                     state_in     = ST_SCAN;
                  end
               end else if (req_command == pba_pkg::CMD_QUERY) begin
                  if (XW'(req_page_number) >= lim_x) begin
                     status_in  = pba_pkg::STATUS_REJECTED;
                     isalloc_in = 1'b1;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = AW'(req_page_number >> LB);
                     state_in = ST_QUERY;
                  end
               end else if (req_command == pba_pkg::CMD_FREE ||
                            req_command == pba_pkg::CMD_RESERVE ||
                            req_command == pba_pkg::CMD_UNRESERVE) begin
                  if (req_page_count == '0) begin
                     status_in = pba_pkg::STATUS_DONE;
                  end else if (XW'(req_page_number) >= lim_x) begin
                     status_in = pba_pkg::STATUS_REJECTED;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = AW'(req_page_number >> LB);
                     word_in  = AW'(req_page_number >> LB);
                     last_in  = AW'((req_hi - XW'(1)) >> LB);
                     lo_in    = XW'(req_page_number);
                     hi_in    = req_hi;
                     state_in = ST_WRITE;
                  end
               end else begin
                  status_in = pba_pkg::STATUS_REJECTED;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               start_in = found_page;
               lo_in    = found_page;
               hi_in    = new_hi;
               word_in  = AW'(found_page >> LB);
               last_in  = AW'((new_hi - XW'(1)) >> LB);
               rd_en    = 1'b1;
               rd_addr  = AW'(found_page >> LB);
               free_in  = free_alloc;
               alloc_in = alloc_ff + EW'(cnt_ff);
               low_in   = (free_alloc < low_ff) ? free_alloc : low_ff;
               state_in = ST_WRITE;
            end else if (word_ff == last_ff) begin
               status_in = pba_pkg::STATUS_NO_RUN;
               state_in  = ST_REPLY;
            end else begin
               if (!has_v[WB-1]) begin
                  run_start_in = (run_ff == '0) ? base : run_start_ff;
                  run_in       = run_ff + XW'(WB);
               end else begin
                  run_in       = XW'(WB - 1) - XW'(lastk_v[WB-1]);
                  run_start_in = base + XW'(lastk_v[WB-1]) + XW'(1);
               end
               rd_en   = 1'b1;
               word_in = word_ff + AW'(1);
            end
         end
         ST_WRITE: begin
            unique case (cmd_ff)
               pba_pkg::CMD_FREE: begin
                  free_in  = free_ff + LW'(changed_n);
                  freed_in = freed_ff + EW'(changed_n);
               end
               pba_pkg::CMD_RESERVE: begin
                  free_in = (free_ff > LW'(changed_n)) ? (free_ff - LW'(changed_n)) : '0;
                  resv_in = resv_ff + EW'(range_n);
               end
               pba_pkg::CMD_UNRESERVE: begin
                  free_in = free_ff + LW'(changed_n);
                  resv_in = (resv_ff > EW'(range_n)) ? (resv_ff - EW'(range_n)) : '0;
               end
               default: begin
               end
            endcase
            if (word_ff == last_ff) begin
               state_in = ST_REPLY;
            end else begin
               rd_en   = 1'b1;
               word_in = word_ff + AW'(1);
            end
         end
         ST_QUERY: begin
            isalloc_in = word_q[bit_sel_ff];
            state_in   = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_ff       <= '0;
         low_ff        <= pba_pkg::LOW_WATER_RESET;
         resv_ff       <= '0;
         alloc_ff      <= '0;
         freed_ff      <= '0;
         page_limit_ff <= '0;
         enabled_ff    <= 1'b0;
         row_valid_ff  <= '0;
         rowv_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         free_ff  <= free_in;
         low_ff   <= low_in;
         resv_ff  <= resv_in;
         alloc_ff <= alloc_in;
         freed_ff <= freed_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == pba_pkg::CSR_PAGE_LIMIT) begin
               page_limit_ff <= csr_data;
            end else begin
               enabled_ff <= csr_data[0];
            end
         end
         if (wr_en) begin
            row_valid_ff[word_ff] <= 1'b1;
         end
         if (rd_en) begin
            rowv_ff <= row_valid_ff[rd_addr];
         end
         if (state_ff == ST_REPLY && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      cnt_ff       <= cnt_in;
      word_ff      <= word_in;
      last_ff      <= last_in;
      run_ff       <= run_in;
      run_start_ff <= run_start_in;
      bit_sel_ff   <= bit_sel_in;
      status_ff    <= status_in;
      start_ff     <= start_in;
      isalloc_ff   <= isalloc_in;
      if (state_ff == ST_REPLY && out_free) begin
         rsp_status_ff  <= status_ff;
         rsp_start_ff   <= pba_pkg::PAGE_W'(start_ff);
         rsp_isalloc_ff <= isalloc_ff;
         rsp_free_ff    <= free_ff;
         rsp_low_ff     <= low_ff;
         rsp_resv_ff    <= resv_ff;
         rsp_alloc_ff   <= alloc_ff;
         rsp_freed_ff   <= freed_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_first_page       = rsp_start_ff;
   assign rsp_is_allocated     = rsp_isalloc_ff;
   assign rsp_free_total       = rsp_free_ff;
   assign rsp_free_low_water   = rsp_low_ff;
   assign rsp_reserved_total   = rsp_resv_ff;
   assign rsp_allocated_events = rsp_alloc_ff;
   assign rsp_freed_events     = rsp_freed_ff;

   a_write_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (word_ff <= last_ff))
      else $error("map write beyond the last word of the range");

   a_free_bounded : assert property (@(posedge clock) disable iff (reset)
      free_ff <= LW'(LIM_MAX))
      else $error("free page count exceeds the pages managed");

   a_reply_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_REPLY))
      else $error("result word raised outside the reply state");

endmodule
